// ===== rtl/core/pvm_pkg.sv =====
// ----------------------------------------------------------------------------
// pvm_pkg: shared types and arithmetic helpers for the pose to view matrix
// Widths, payload structs, inter-stage struct and the round / saturate
// functions used by the rotation and translation pipelines.
// ----------------------------------------------------------------------------
package pvm_pkg;

  localparam int QUAT_WIDTH = 16;
  localparam int POS_WIDTH  = 32;
  localparam int QF         = QUAT_WIDTH - 2;
  localparam int ROT_W      = 16;
  localparam int TR_W       = 32;

  // quaternion products (Q3.28) and rotation sums (Q6.28) at the default width
  localparam int PROD_W   = 2 * QUAT_WIDTH;
  localparam int RSUM_W   = PROD_W + 3;
  localparam int RSH_W    = ((RSUM_W - QF) > ROT_W) ? (RSUM_W - QF) : (ROT_W + 1);

  // rotation entry times position, and the three-term dot product
  localparam int TPROD_W  = ROT_W + POS_WIDTH;
  localparam int TSUM_W   = TPROD_W + 2;
  localparam int TSH_W    = ((TSUM_W - QF + 1) > TR_W) ? (TSUM_W - QF + 1) : (TR_W + 1);

  localparam logic signed [RSUM_W-1:0] ONE_R = RSUM_W'(1) << (2 * QF);
  localparam logic signed [RSUM_W-1:0] RND_R = RSUM_W'(1) << (QF - 1);
  localparam logic signed [TSUM_W-1:0] RND_T = TSUM_W'(1) << (QF - 1);

  localparam logic signed [RSH_W-1:0] ROT_MAX =
    {{(RSH_W - ROT_W + 1){1'b0}}, {(ROT_W - 1){1'b1}}};
  localparam logic signed [RSH_W-1:0] ROT_MIN = ~ROT_MAX;
  localparam logic signed [TSH_W-1:0] TR_MAX =
    {{(TSH_W - TR_W + 1){1'b0}}, {(TR_W - 1){1'b1}}};
  localparam logic signed [TSH_W-1:0] TR_MIN = ~TR_MAX;

  typedef logic signed [QUAT_WIDTH-1:0] quat_e_t;
  typedef logic signed [POS_WIDTH-1:0]  pos_e_t;
  typedef logic signed [ROT_W-1:0]      rot_e_t;
  typedef logic signed [TR_W-1:0]       tr_e_t;

  typedef struct packed {
    quat_e_t quat_x;
    quat_e_t quat_y;
    quat_e_t quat_z;
    quat_e_t quat_w;
    pos_e_t  pos_x;
    pos_e_t  pos_y;
    pos_e_t  pos_z;
  } pose_t;

  typedef struct packed {
    rot_e_t m00;
    rot_e_t m01;
    rot_e_t m02;
    rot_e_t m10;
    rot_e_t m11;
    rot_e_t m12;
    rot_e_t m20;
    rot_e_t m21;
    rot_e_t m22;
    tr_e_t  trans_x;
    tr_e_t  trans_y;
    tr_e_t  trans_z;
  } view_t;

  // rotation matrix r[row][col] and position, handed to the translation side
  typedef struct packed {
    logic                    valid;
    rot_e_t [2:0][2:0]       r;
    pos_e_t [2:0]            p;
  } rot_stage_t;

  // round half towards plus infinity, then saturate to a rotation entry
  function automatic rot_e_t rot_round_sat(input logic signed [RSUM_W-1:0] v);
    logic signed [RSUM_W-1:0] t;
    logic signed [RSH_W-1:0]  s;
    t = (v + RND_R) >>> QF;
    s = RSH_W'(t);
    if (s > ROT_MAX) begin
      return ROT_MAX[ROT_W-1:0];
    end else if (s < ROT_MIN) begin
      return ROT_MIN[ROT_W-1:0];
    end
    return ROT_W'(s);
  endfunction

  // round half towards plus infinity, negate, saturate to a translation term
  function automatic tr_e_t tr_round_neg_sat(input logic signed [TSUM_W-1:0] v);
    logic signed [TSUM_W-1:0] t;
    logic signed [TSH_W-1:0]  s;
    t = (v + RND_T) >>> QF;
    s = -TSH_W'(t);
    if (s > TR_MAX) begin
      return TR_MAX[TR_W-1:0];
    end else if (s < TR_MIN) begin
      return TR_MIN[TR_W-1:0];
    end
    return TR_W'(s);
  endfunction

endpackage

// ===== rtl/core/pose_to_view_matrix.sv =====
// Four register stages (quaternion products, rotation round, position
// products, translation sum and output register) lie between the start
// cycle and the result strobe done.
// Throughput: one pose per cycle; busy is never raised, the receiver cannot stall.
// Reset clears only the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// pose_to_view_matrix: quaternion pose to view matrix
// Builds the rotation from a quaternion and returns its transpose together
// with the negated, rotated position as the view translation.
// ----------------------------------------------------------------------------
module pose_to_view_matrix
  import pvm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  pose_t pose,
  output logic  done,
  output view_t view
);

  rot_stage_t rot;

  // every stage advances each cycle, so a transaction is always taken
  assign busy = 1'b0;

  pvm_rot u_rot (
    .clk   (clk),
    .rst   (rst),
    .start (start & ~busy),
    .pose  (pose),
    .rot   (rot)
  );

  pvm_trans u_trans (
    .clk  (clk),
    .rst  (rst),
    .rot  (rot),
    .done (done),
    .view (view)
  );

endmodule

// ===== rtl/core/pvm_rot.sv =====
// ----------------------------------------------------------------------------
// pvm_rot: quaternion to rotation matrix
// Stage one forms the nine quaternion products, stage two combines them into
// the nine doubled-product entries and rounds and saturates each to Q1.14.
// ----------------------------------------------------------------------------
module pvm_rot
  import pvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  pose_t      pose,
  output rot_stage_t rot
);

  logic                    s1_valid;
  logic signed [PROD_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  pos_e_t [2:0]            s1_p;

  logic signed [RSUM_W-1:0] r_next [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    xx      <= pose.quat_x * pose.quat_x;
    yy      <= pose.quat_y * pose.quat_y;
    zz      <= pose.quat_z * pose.quat_z;
    xy      <= pose.quat_x * pose.quat_y;
    xz      <= pose.quat_x * pose.quat_z;
    yz      <= pose.quat_y * pose.quat_z;
    wx      <= pose.quat_w * pose.quat_x;
    wy      <= pose.quat_w * pose.quat_y;
    wz      <= pose.quat_w * pose.quat_z;
    s1_p[0] <= pose.pos_x;
    s1_p[1] <= pose.pos_y;
    s1_p[2] <= pose.pos_z;
  end

  always_comb begin
    r_next[0][0] = ONE_R - ((RSUM_W'(yy) + RSUM_W'(zz)) <<< 1);
    r_next[0][1] = (RSUM_W'(xy) - RSUM_W'(wz)) <<< 1;
    r_next[0][2] = (RSUM_W'(xz) + RSUM_W'(wy)) <<< 1;
    r_next[1][0] = (RSUM_W'(xy) + RSUM_W'(wz)) <<< 1;
    r_next[1][1] = ONE_R - ((RSUM_W'(xx) + RSUM_W'(zz)) <<< 1);
    r_next[1][2] = (RSUM_W'(yz) - RSUM_W'(wx)) <<< 1;
    r_next[2][0] = (RSUM_W'(xz) - RSUM_W'(wy)) <<< 1;
    r_next[2][1] = (RSUM_W'(yz) + RSUM_W'(wx)) <<< 1;
    r_next[2][2] = ONE_R - ((RSUM_W'(xx) + RSUM_W'(yy)) <<< 1);
  end

  // only the valid bit is reset; the data fields simply advance
  always_ff @(posedge clk) begin
    if (rst) begin
      rot.valid <= 1'b0;
    end else begin
      rot.valid <= s1_valid;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot.r[i][j] <= rot_round_sat(r_next[i][j]);
      end
    end
    rot.p <= s1_p;
  end

endmodule

// ===== rtl/core/pvm_trans.sv =====
// ----------------------------------------------------------------------------
// pvm_trans: view translation and output register
// Stage three multiplies each rotation entry by its position component,
// stage four sums each column, rounds, negates and saturates, and registers
// the transposed rotation alongside the translation.
// ----------------------------------------------------------------------------
module pvm_trans
  import pvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  rot_stage_t rot,
  output logic       done,
  output view_t      view
);

  logic                      s3_valid;
  logic signed [TPROD_W-1:0] prod [3][3];
  rot_e_t [2:0][2:0]         s3_r;

  logic signed [TSUM_W-1:0]  acc [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= rot.valid;
    end
  end

  // prod[i][j] = r[i][j] * p[i]
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] <= $signed(rot.r[i][j]) * $signed(rot.p[i]);
      end
    end
    s3_r <= rot.r;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = TSUM_W'(prod[0][j]) + TSUM_W'(prod[1][j]) + TSUM_W'(prod[2][j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

  // rotation leaves transposed: view row i, col j is r[j][i]
  always_ff @(posedge clk) begin
    view.m00     <= s3_r[0][0];
    view.m01     <= s3_r[1][0];
    view.m02     <= s3_r[2][0];
    view.m10     <= s3_r[0][1];
    view.m11     <= s3_r[1][1];
    view.m12     <= s3_r[2][1];
    view.m20     <= s3_r[0][2];
    view.m21     <= s3_r[1][2];
    view.m22     <= s3_r[2][2];
    view.trans_x <= tr_round_neg_sat(acc[0]);
    view.trans_y <= tr_round_neg_sat(acc[1]);
    view.trans_z <= tr_round_neg_sat(acc[2]);
  end

endmodule

// ===== tb/pose_to_view_matrix_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_to_view_matrix_test: self-checking bench for the pose to view matrix
// Sends directed and random poses through the command interface with random
// gaps, none in the back-to-back test. Each accepted pose is run through a
// local fixed-point model of the view matrix. Every strobed result is checked
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module pose_to_view_matrix_test;
  import pvm_pkg::*;

  localparam int      CYCLE_LIMIT = 200000;
  localparam int      IDLE_PCT    = 37;
  localparam int      DRAIN_WAIT  = 8;
  localparam quat_e_t Q_ONE       = 16'sd16384;
  localparam pos_e_t  POS_MAX     = 32'sh7fff_ffff;
  localparam pos_e_t  POS_MIN     = 32'sh8000_0000;
  localparam pos_e_t  POS_ONE     = 32'sh0001_0000;

  logic   clk   = 1'b0;
  logic   rst   = 1'b1;
  logic   start = 1'b0;
  pose_t  pose  = '0;
  logic   busy;
  logic   done;
  view_t  view;

  view_t  pending_views[$];
  int     failures    = 0;
  int     cycle_count = 0;
  int     idle_pct    = IDLE_PCT;

  string  field_names[12] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                              "m20", "m21", "m22", "trans_x", "trans_y", "trans_z"};

  pose_to_view_matrix uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .pose  (pose),
    .done  (done),
    .view  (view)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model --

  function automatic longint round_half_up(input longint v);
    return (v + (64'sd1 <<< (QF - 1))) >>> QF;
  endfunction

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic view_t predict_view(input pose_t p);
    longint x, y, z, w;
    longint one;
    longint pv[3];
    longint r[3][3];
    longint q[3][3];
    longint acc;
    longint tr[3];
    view_t  v;
    x = $signed(p.quat_x);
    y = $signed(p.quat_y);
    z = $signed(p.quat_z);
    w = $signed(p.quat_w);
    pv[0] = $signed(p.pos_x);
    pv[1] = $signed(p.pos_y);
    pv[2] = $signed(p.pos_z);
    one = 64'sd1 <<< (2 * QF);
    r[0][0] = one - 2 * (y * y + z * z);
    r[0][1] = 2 * (x * y - w * z);
    r[0][2] = 2 * (x * z + w * y);
    r[1][0] = 2 * (x * y + w * z);
    r[1][1] = one - 2 * (x * x + z * z);
    r[1][2] = 2 * (y * z - w * x);
    r[2][0] = 2 * (x * z - w * y);
    r[2][1] = 2 * (y * z + w * x);
    r[2][2] = one - 2 * (x * x + y * y);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        q[i][j] = clamp_to(round_half_up(r[i][j]), ROT_W);
      end
    end
    // translation uses the rounded, saturated entries of each rotation column
    for (int j = 0; j < 3; j++) begin
      acc   = q[0][j] * pv[0] + q[1][j] * pv[1] + q[2][j] * pv[2];
      tr[j] = clamp_to(-round_half_up(acc), TR_W);
    end
    v.m00     = rot_e_t'(q[0][0]);
    v.m01     = rot_e_t'(q[1][0]);
    v.m02     = rot_e_t'(q[2][0]);
    v.m10     = rot_e_t'(q[0][1]);
    v.m11     = rot_e_t'(q[1][1]);
    v.m12     = rot_e_t'(q[2][1]);
    v.m20     = rot_e_t'(q[0][2]);
    v.m21     = rot_e_t'(q[1][2]);
    v.m22     = rot_e_t'(q[2][2]);
    v.trans_x = tr_e_t'(tr[0]);
    v.trans_y = tr_e_t'(tr[1]);
    v.trans_z = tr_e_t'(tr[2]);
    return v;
  endfunction

  // -------------------------------------------------------------- checker --

  function automatic void view_fields(input view_t v, output longint f[12]);
    f[0]  = $signed(v.m00);
    f[1]  = $signed(v.m01);
    f[2]  = $signed(v.m02);
    f[3]  = $signed(v.m10);
    f[4]  = $signed(v.m11);
    f[5]  = $signed(v.m12);
    f[6]  = $signed(v.m20);
    f[7]  = $signed(v.m21);
    f[8]  = $signed(v.m22);
    f[9]  = $signed(v.trans_x);
    f[10] = $signed(v.trans_y);
    f[11] = $signed(v.trans_z);
  endfunction

  task automatic compare_view(input view_t want, input view_t got);
    longint fw[12];
    longint fg[12];
    view_fields(want, fw);
    view_fields(got, fg);
    for (int i = 0; i < 12; i++) begin
      if (fw[i] != fg[i]) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch on %s: expected %0d, got %0d", field_names[i], fw[i], fg[i]);
        end
      end
    end
  endtask

  // sample everything on the edge that accepts it; predict before checking
  always @(posedge clk) begin
    view_t want;
    if (!rst) begin
      if (start && !busy) begin
        pending_views.push_back(predict_view(pose));
      end
      if (done) begin
        if (pending_views.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("result strobed with no pose pending: %h", view);
          end
        end else begin
          want = pending_views.pop_front();
          compare_view(want, view);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------- driving --

  task automatic send_pose(input pose_t p);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pose  <= p;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  function automatic pose_t make_pose(input quat_e_t qx, input quat_e_t qy,
                                      input quat_e_t qz, input quat_e_t qw,
                                      input pos_e_t px, input pos_e_t py,
                                      input pos_e_t pz);
    pose_t p;
    p.quat_x = qx;
    p.quat_y = qy;
    p.quat_z = qz;
    p.quat_w = qw;
    p.pos_x  = px;
    p.pos_y  = py;
    p.pos_z  = pz;
    return p;
  endfunction

  // mostly room-scale positions, now and then the full range or a rail
  function automatic pos_e_t random_position();
    case ($urandom_range(9))
      0:       return pos_e_t'($urandom);
      1:       return $urandom_range(1) ? POS_MAX : POS_MIN;
      2:       return pos_e_t'(int'($urandom_range(0, 33554431)) - 16777216);
      default: return pos_e_t'(int'($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests --

  task automatic test_directed_poses();
    send_pose(make_pose(0, 0, 0, Q_ONE, 0, 0, 0));
    send_pose(make_pose(0, 0, 0, Q_ONE, POS_ONE, -2 * POS_ONE, 32'sh0003_8000));
    send_pose(make_pose(0, 0, 0, 0, POS_MAX, POS_MIN, POS_MAX));
    // identity with the position on its rails: negating the minimum saturates
    send_pose(make_pose(0, 0, 0, Q_ONE, POS_MAX, POS_MAX, POS_MAX));
    send_pose(make_pose(0, 0, 0, Q_ONE, POS_MIN, POS_MIN, POS_MIN));
    send_pose(make_pose(Q_ONE, 0, 0, 0, POS_ONE, POS_ONE, POS_ONE));
    send_pose(make_pose(0, Q_ONE, 0, 0, POS_ONE, -POS_ONE, POS_ONE));
    send_pose(make_pose(0, 0, Q_ONE, 0, -POS_ONE, POS_ONE, POS_ONE));
    send_pose(make_pose(0, 0, 11585, 11585, 5 * POS_ONE, 7 * POS_ONE, -POS_ONE));
    send_pose(make_pose(-Q_ONE, 0, 0, 0, 12345, -6789, 1011));
    send_pose(make_pose(0, 0, 0, -Q_ONE, 12345, -6789, 1011));
    // quaternions far from unit length, most driving the diagonal entries into saturation
    send_pose(make_pose(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                        POS_MIN, POS_MIN, POS_MIN));
    send_pose(make_pose(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        POS_MAX, POS_MAX, POS_MAX));
    send_pose(make_pose(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                        POS_MAX, POS_MIN, POS_ONE));
    send_pose(make_pose(0, 0, 0, 16'sh8000, POS_ONE, POS_ONE, POS_ONE));
    // exact half steps in rounding, positive and negative
    send_pose(make_pose(64, 64, 0, 0, 8192, -8192, 1));
    send_pose(make_pose(64, -64, 0, 0, -8192, 8192, -1));
    send_pose(make_pose(64, 64, 0, 0, 1, 1, 0));
    send_pose(make_pose(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                        32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555));
    send_pose(make_pose(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
                        32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa));
  endtask

  task automatic test_unit_quaternions(input int count);
    real   a[4];
    real   norm;
    quat_e_t qc[4];
    for (int n = 0; n < count; n++) begin
      do begin
        for (int k = 0; k < 4; k++) begin
          a[k] = ($urandom_range(0, 65535) - 32768.0) / 32768.0;
        end
        norm = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
      end while (norm < 0.01);
      for (int k = 0; k < 4; k++) begin
        qc[k] = quat_e_t'($rtoi(a[k] / norm * Q_ONE + ((a[k] >= 0.0) ? 0.5 : -0.5)));
      end
      send_pose(make_pose(qc[0], qc[1], qc[2], qc[3],
                          random_position(), random_position(), random_position()));
    end
  endtask

  task automatic test_back_to_back_poses(input int count);
    idle_pct = 0;
    test_unit_quaternions(count);
    idle_pct = IDLE_PCT;
  endtask

  task automatic test_raw_poses(input int count);
    for (int n = 0; n < count; n++) begin
      send_pose(make_pose(quat_e_t'($urandom), quat_e_t'($urandom),
                          quat_e_t'($urandom), quat_e_t'($urandom),
                          pos_e_t'($urandom), random_position(), pos_e_t'($urandom)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_poses();
    test_unit_quaternions(500);
    test_back_to_back_poses(200);
    test_raw_poses(350);
    start <= 1'b0;
    while (pending_views.size() != 0) begin
      @(posedge clk);
    end
    // keep clocking to catch any stray result strobes
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pvm_pkg.sv
rtl/core/pvm_rot.sv
rtl/core/pvm_trans.sv
rtl/core/pose_to_view_matrix.sv
tb/pose_to_view_matrix_test.sv
